[src/tpss_pkg.sv]
// ----------------------------------------------------------------------------
// tpss_pkg
// Shared types, codes and constants for the tilt position and stillness
// session unit.
// ----------------------------------------------------------------------------
package tpss_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [1:0] REG_ONE_G      = 2'd0;
	localparam logic [1:0] REG_POS_AFTER  = 2'd1;
	localparam logic [1:0] REG_SESS_AFTER = 2'd2;

	localparam logic [14:0] ONE_G_RESET      = 15'd4096;
	localparam logic [15:0] POS_AFTER_RESET  = 16'd750;
	localparam logic [15:0] SESS_AFTER_RESET = 16'd2250;

	localparam logic [29:0] G2_RESET   = 30'(32'd4096 * 32'd4096);
	localparam logic [38:0] G289_RESET = 39'(64'(G2_RESET) * 64'd289);
	localparam logic [39:0] G529_RESET = 40'(64'(G2_RESET) * 64'd529);

	localparam logic [2:0] POS_NONE     = 3'd0;
	localparam logic [2:0] POS_LEFT     = 3'd1;
	localparam logic [2:0] POS_RIGHT    = 3'd2;
	localparam logic [2:0] POS_INVERTED = 3'd3;
	localparam logic [2:0] POS_SIDEWAYS = 3'd4;

	localparam logic [1:0] SIDE_NONE  = 2'd0;
	localparam logic [1:0] SIDE_LEFT  = 2'd1;
	localparam logic [1:0] SIDE_RIGHT = 2'd2;

	localparam logic [1:0] PHASE_IDLE        = 2'd0;
	localparam logic [1:0] PHASE_POSITIONING = 2'd1;
	localparam logic [1:0] PHASE_SESSION     = 2'd2;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
	} sample_t;

	typedef struct packed {
		logic [2:0] position_class;
		logic [1:0] active_side;
		logic [1:0] session_state;
	} result_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [2:0] pos;
		logic       still;
	} qent_t;

	typedef struct packed {
		logic [29:0] g2;
		logic [38:0] g289;
		logic [39:0] g529;
		logic [15:0] pos_after;
		logic [15:0] sess_after;
	} cfg_t;

endpackage

[src/tpss_cfg.sv]
// ----------------------------------------------------------------------------
// tpss_cfg
// APB register file with registered one-g square terms for the classifier.
// ----------------------------------------------------------------------------
module tpss_cfg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [tpss_pkg::ADDR_W-1:0] paddr,
	input  logic [tpss_pkg::DATA_W-1:0] pwdata,
	output logic [tpss_pkg::DATA_W-1:0] prdata,
	output logic                   pready,
	output tpss_pkg::cfg_t         cfg
);
	import tpss_pkg::*;

	logic [14:0] one_g_q;
	logic [15:0] pos_after_q;
	logic [15:0] sess_after_q;
	logic [29:0] g2_q;
	logic [38:0] g289_q;
	logic [39:0] g529_q;
	logic        wr;
	logic [1:0]  idx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_g_q      <= ONE_G_RESET;
			pos_after_q  <= POS_AFTER_RESET;
			sess_after_q <= SESS_AFTER_RESET;
			g2_q         <= G2_RESET;
			g289_q       <= G289_RESET;
			g529_q       <= G529_RESET;
		end else begin
			if (wr) begin
				case (idx)
					REG_ONE_G:      one_g_q      <= pwdata[14:0];
					REG_POS_AFTER:  pos_after_q  <= pwdata[15:0];
					REG_SESS_AFTER: sess_after_q <= pwdata[15:0];
					default: ;
				endcase
			end
			g2_q   <= 30'(one_g_q) * 30'(one_g_q);
			g289_q <= 39'(g2_q) * 39'd289;
			g529_q <= 40'(g2_q) * 40'd529;
		end
	end

	always_comb begin
		case (idx)
			REG_ONE_G:      prdata = DATA_W'(one_g_q);
			REG_POS_AFTER:  prdata = DATA_W'(pos_after_q);
			REG_SESS_AFTER: prdata = DATA_W'(sess_after_q);
			default:        prdata = '0;
		endcase
	end

	assign cfg.g2         = g2_q;
	assign cfg.g289       = g289_q;
	assign cfg.g529       = g529_q;
	assign cfg.pos_after  = pos_after_q;
	assign cfg.sess_after = sess_after_q;

endmodule

[src/tpss_front.sv]
// ----------------------------------------------------------------------------
// tpss_front
// Sample pipeline: squares, magnitude sum, scaled terms, then position class
// and stillness flag pushed to the queue.
// ----------------------------------------------------------------------------
module tpss_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  tpss_pkg::sample_t sample,
	input  tpss_pkg::cfg_t    cfg,
	input  logic              q_full,
	output logic              q_push,
	output tpss_pkg::qent_t   q_data
);
	import tpss_pkg::*;

	typedef struct packed {
		logic ypos;
		logic yneg;
		logic zpos;
		logic zneg;
	} sgn_t;

	logic              en;
	logic signed [31:0] px, py, pz;

	logic        v_s1, v_s2, v_s3;
	logic [30:0] xx_s1, yy_s1, zz_s1;
	logic [30:0] xx_s2, yy_s2, zz_s2;
	logic [31:0] s_s2;
	sgn_t        sg_s1, sg_s2, sg_s3;

	logic [33:0] s4_s3;
	logic [40:0] s400_s3, s289_s3, zz400_s3;
	logic [37:0] s49_s3, xx100_s3;
	logic [32:0] s1x_s3, yy4_s3, zz4_s3;

	logic nodata, upright, sideways, lefty, righty, inverted, still;

	assign en           = !q_full;
	assign sample_stall = q_full;

	assign px = sample.accel_x * sample.accel_x;
	assign py = sample.accel_y * sample.accel_y;
	assign pz = sample.accel_z * sample.accel_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= sample_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1      <= px[30:0];
			yy_s1      <= py[30:0];
			zz_s1      <= pz[30:0];
			sg_s1.ypos <= !sample.accel_y[15] && (sample.accel_y != 16'sd0);
			sg_s1.yneg <= sample.accel_y[15];
			sg_s1.zpos <= !sample.accel_z[15] && (sample.accel_z != 16'sd0);
			sg_s1.zneg <= sample.accel_z[15];

			xx_s2 <= xx_s1;
			yy_s2 <= yy_s1;
			zz_s2 <= zz_s1;
			s_s2  <= 32'(xx_s1) + 32'(yy_s1) + 32'(zz_s1);
			sg_s2 <= sg_s1;

			s4_s3    <= {s_s2, 2'b00};
			s400_s3  <= 41'(s_s2) * 41'd400;
			s289_s3  <= 41'(s_s2) * 41'd289;
			zz400_s3 <= 41'(zz_s2) * 41'd400;
			s49_s3   <= 38'(s_s2) * 38'd49;
			xx100_s3 <= 38'(xx_s2) * 38'd100;
			s1x_s3   <= 33'(s_s2);
			yy4_s3   <= {yy_s2, 2'b00};
			zz4_s3   <= {zz_s2, 2'b00};
			sg_s3    <= sg_s2;
		end
	end

	assign nodata   = s4_s3 < 34'(cfg.g2);
	assign upright  = sg_s3.zpos && (zz400_s3 > s289_s3);
	assign sideways = xx100_s3 > s49_s3;
	assign lefty    = sg_s3.ypos && (yy4_s3 > s1x_s3);
	assign righty   = sg_s3.yneg && (yy4_s3 > s1x_s3);
	assign inverted = sg_s3.zneg && (zz4_s3 > s1x_s3);
	assign still    = (s400_s3 > 41'(cfg.g289)) && (s400_s3 < 41'(cfg.g529));

	always_comb begin
		if (nodata || upright) q_data.pos = POS_NONE;
		else if (sideways)     q_data.pos = POS_SIDEWAYS;
		else if (lefty)        q_data.pos = POS_LEFT;
		else if (righty)       q_data.pos = POS_RIGHT;
		else if (inverted)     q_data.pos = POS_INVERTED;
		else                   q_data.pos = POS_NONE;
		q_data.still = still;
	end

	assign q_push = v_s3 && en;

endmodule

[src/tpss_queue.sv]
// ----------------------------------------------------------------------------
// tpss_queue
// Small FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module tpss_queue #(
	parameter int DEPTH = tpss_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tpss_pkg::qent_t wdata,
	input  logic            pop,
	output logic            nonempty,
	output logic            full,
	output tpss_pkg::qent_t rdata
);
	import tpss_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	qent_t         mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	assign nonempty = cnt_q != '0;
	assign full     = cnt_q == CW'(DEPTH);
	assign rdata    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

[src/tpss_back.sv]
// ----------------------------------------------------------------------------
// tpss_back
// Still-count and session state update, result output register.
// ----------------------------------------------------------------------------
module tpss_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_nonempty,
	input  tpss_pkg::qent_t   q_data,
	output logic              q_pop,
	input  tpss_pkg::cfg_t    cfg,
	output logic              result_valid,
	input  logic              result_stall,
	output tpss_pkg::result_t result
);
	import tpss_pkg::*;

	logic [15:0] cnt_q, cnt_nx;
	logic [1:0]  phase_q, phase_nx;
	logic [1:0]  side_nx;
	logic        valid_q;
	result_t     res_q;

	assign q_pop = q_nonempty && (!valid_q || !result_stall);

	always_comb begin
		side_nx = SIDE_NONE;
		if (q_data.pos == POS_NONE) begin
			cnt_nx   = '0;
			phase_nx = PHASE_IDLE;
		end else begin
			if (q_data.still) cnt_nx = (cnt_q == 16'hFFFF) ? cnt_q : cnt_q + 16'd1;
			else              cnt_nx = '0;
			if (cnt_nx > cfg.sess_after) begin
				phase_nx = PHASE_SESSION;
				side_nx  = (q_data.pos == POS_RIGHT) ? SIDE_RIGHT : SIDE_LEFT;
			end else if (cnt_nx > cfg.pos_after) begin
				phase_nx = PHASE_POSITIONING;
			end else begin
				phase_nx = phase_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			phase_q <= PHASE_IDLE;
			valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cnt_q   <= cnt_nx;
				phase_q <= phase_nx;
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q.position_class <= q_data.pos;
			res_q.active_side    <= side_nx;
			res_q.session_state  <= phase_nx;
		end
	end

	assign result_valid = valid_q;
	assign result       = res_q;

endmodule

[src/tilt_position_and_stillness_session_unit.sv]
// ----------------------------------------------------------------------------
// tilt_position_and_stillness_session_unit
// Accelerometer position classifier with stillness count and session state.
// ----------------------------------------------------------------------------
// A sample passes the three-stage square/scale pipeline in the front, the
// queue and the result register before its result is valid. One sample per
// cycle is taken while sample_stall is low (the queue is not full).
// Reset clears the pipeline, queue, still count and session state and
// loads the register defaults (4096 counts per g, 750 and 2250).
module tilt_position_and_stillness_session_unit #(
	parameter int QUEUE_DEPTH = tpss_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sample_valid,
	output logic                        sample_stall,
	input  tpss_pkg::sample_t           sample,
	output logic                        result_valid,
	input  logic                        result_stall,
	output tpss_pkg::result_t           result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tpss_pkg::ADDR_W-1:0] paddr,
	input  logic [tpss_pkg::DATA_W-1:0] pwdata,
	output logic [tpss_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import tpss_pkg::*;

	cfg_t  cfg;
	logic  q_full, q_push, q_pop, q_nonempty;
	qent_t q_wdata, q_rdata;

	tpss_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tpss_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.cfg          (cfg),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_wdata)
	);

	tpss_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata    (q_wdata),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.full     (q_full),
		.rdata    (q_rdata)
	);

	tpss_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_nonempty   (q_nonempty),
		.q_data       (q_rdata),
		.q_pop        (q_pop),
		.cfg          (cfg),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

[src/tpss_checker.sv]
// ----------------------------------------------------------------------------
// tpss_checker
// Port-level checks on result items of the session unit.
// ----------------------------------------------------------------------------
module tpss_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_stall,
	input tpss_pkg::result_t result
);
	import tpss_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result item changed while stalled");

	a_side_session: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.active_side != SIDE_NONE)
		|-> result.session_state == PHASE_SESSION)
		else $error("side reported outside active session");

	a_upright_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.position_class == POS_NONE)
		|-> (result.session_state == PHASE_IDLE) && (result.active_side == SIDE_NONE))
		else $error("upright item with nonidle session");

	a_right_side: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.active_side == SIDE_RIGHT)
		|-> result.position_class == POS_RIGHT)
		else $error("right side without right tilt");

endmodule

bind tilt_position_and_stillness_session_unit tpss_checker u_tpss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
